// ----- rtl/core/ndiv_pkg.sv -----
`timescale 1ns / 1ps

package ndiv_pkg;

  localparam int FIELD_W     = 16;
  localparam int IN_TDATA_W  = 2 * FIELD_W;
  localparam int OUT_TDATA_W = 2 * FIELD_W;

  typedef struct packed {
    logic valid;
    logic dz;
  } ndiv_ctl_t;

endpackage

// ----- rtl/core/nonrestoring_divider.sv -----
`timescale 1ns / 1ps

// channel | direction | tdata (low bit up)              | tuser
// in_     | slave     | dividend, divisor_in            | -
// out_    | master    | quotient, remainder             | divide_by_zero
//
// a chain of WIDTH cells does one add-or-subtract step each, the output
// register applies the final correction and presents the result once its
// transaction has left the last cell; one is taken per cycle unless stalled.
// reset clears the valid bits of every cell and of the output register.
// while a result waits on out_tready the whole chain holds and in_tready is low.

module nonrestoring_divider #(
  parameter int WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ndiv_pkg::IN_TDATA_W-1:0]     in_tdata,   // dividend, divisor_in
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ndiv_pkg::OUT_TDATA_W-1:0]    out_tdata,  // quotient, remainder
  output logic                                out_tuser   // divide_by_zero
);
  import ndiv_pkg::*;

  logic [WIDTH:0]   acc_s [0:WIDTH];
  logic [WIDTH-1:0] q_s   [0:WIDTH];
  logic [WIDTH-1:0] m_s   [0:WIDTH];
  ndiv_ctl_t        ctl_s [0:WIDTH];

  logic                     advance;
  logic [FIELD_W+WIDTH-1:0] dvd_ext;
  logic [FIELD_W+WIDTH-1:0] dvs_ext;
  logic [WIDTH:0]           acc_fix;
  logic [WIDTH-1:0]         quo_w;
  logic [WIDTH-1:0]         rem_w;
  logic [FIELD_W+WIDTH-1:0] quo_ext;
  logic [FIELD_W+WIDTH-1:0] rem_ext;

  logic                     out_tvalid_r;
  logic [OUT_TDATA_W-1:0]   out_tdata_r;
  logic                     out_tuser_r;

  assign advance   = !out_tvalid_r || out_tready;
  assign in_tready = advance;

  assign dvd_ext = {{WIDTH{1'b0}}, in_tdata[FIELD_W-1:0]};
  assign dvs_ext = {{WIDTH{1'b0}}, in_tdata[2*FIELD_W-1:FIELD_W]};

  assign acc_s[0]       = '0;
  assign q_s[0]         = dvd_ext[WIDTH-1:0];
  assign m_s[0]         = dvs_ext[WIDTH-1:0];
  assign ctl_s[0].valid = in_tvalid;
  assign ctl_s[0].dz    = (dvs_ext[WIDTH-1:0] == '0);

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    ndiv_cell #(.W(WIDTH)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (advance),
      .ctl_i (ctl_s[i]),
      .acc_i (acc_s[i]),
      .q_i   (q_s[i]),
      .m_i   (m_s[i]),
      .ctl_o (ctl_s[i+1]),
      .acc_o (acc_s[i+1]),
      .q_o   (q_s[i+1]),
      .m_o   (m_s[i+1])
    );
  end

  always_comb begin
    if (acc_s[WIDTH][WIDTH]) begin
      acc_fix = acc_s[WIDTH] + {1'b0, m_s[WIDTH]};
    end else begin
      acc_fix = acc_s[WIDTH];
    end
    if (ctl_s[WIDTH].dz) begin
      quo_w = '1;
      rem_w = q_s[WIDTH];
    end else begin
      quo_w = q_s[WIDTH];
      rem_w = acc_fix[WIDTH-1:0];
    end
    quo_ext = {{FIELD_W{1'b0}}, quo_w};
    rem_ext = {{FIELD_W{1'b0}}, rem_w};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (advance) begin
      out_tvalid_r <= ctl_s[WIDTH].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tdata_r <= {rem_ext[FIELD_W-1:0], quo_ext[FIELD_W-1:0]};
      out_tuser_r <= ctl_s[WIDTH].dz;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ----- rtl/core/ndiv_cell.sv -----
`timescale 1ns / 1ps

module ndiv_cell #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  ndiv_pkg::ndiv_ctl_t ctl_i,
  input  logic [W:0]          acc_i,
  input  logic [W-1:0]        q_i,
  input  logic [W-1:0]        m_i,
  output ndiv_pkg::ndiv_ctl_t ctl_o,
  output logic [W:0]          acc_o,
  output logic [W-1:0]        q_o,
  output logic [W-1:0]        m_o
);
  import ndiv_pkg::*;

  ndiv_ctl_t    ctl_r;
  logic [W:0]   acc_r;
  logic [W-1:0] q_r;
  logic [W-1:0] m_r;
  logic [W:0]   shifted;
  logic [W:0]   acc_nxt;
  logic [W-1:0] q_nxt;

  always_comb begin
    shifted = {acc_i[W-1:0], q_i[W-1]};
    if (ctl_i.dz) begin
      acc_nxt = acc_i;
      q_nxt   = q_i;
    end else begin
      // add back when the accumulator went negative, otherwise subtract
      if (acc_i[W]) begin
        acc_nxt = shifted + {1'b0, m_i};
      end else begin
        acc_nxt = shifted - {1'b0, m_i};
      end
      q_nxt = {q_i[W-2:0], ~acc_nxt[W]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
      q_r   <= q_nxt;
      m_r   <= m_i;
    end
  end

  assign ctl_o = ctl_r;
  assign acc_o = acc_r;
  assign q_o   = q_r;
  assign m_o   = m_r;

endmodule

// ----- rtl/core/ndiv_chk.sv -----
`timescale 1ns / 1ps

module ndiv_chk #(
  parameter int WIDTH = 16
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ndiv_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser
);
  import ndiv_pkg::*;

  localparam logic [FIELD_W-1:0] QMASK =
    (WIDTH >= FIELD_W) ? {FIELD_W{1'b1}} : FIELD_W'((64'd1 << WIDTH) - 64'd1);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_chain_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while result stalled");

  a_dz_quotient: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[FIELD_W-1:0] == QMASK)
    else $error("zero divisor result without all-ones quotient");

endmodule

bind nonrestoring_divider ndiv_chk #(.WIDTH(WIDTH)) u_ndiv_chk (.*);
